// File: sv/jads_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package jads_pkg;

  localparam int DATA_W    = 16;
  localparam int DELTA_W   = 8;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_CNT_W = $clog2(DATA_W);

  // register slot within one stick's group of four
  localparam logic [1:0] REG_X_MIN = 2'd0;
  localparam logic [1:0] REG_X_MAX = 2'd1;
  localparam logic [1:0] REG_Y_MIN = 2'd2;
  localparam logic [1:0] REG_Y_MAX = 2'd3;

  localparam logic AXIS_X = 1'b0;
  localparam logic AXIS_Y = 1'b1;

  // floor(r / 3) == (r * RECIP3) >> RECIP3_SHIFT for every 16-bit r
  localparam logic [31:0] RECIP3       = 32'd43691;
  localparam int          RECIP3_SHIFT = 17;

  localparam logic [6:0] SAT_MAG = 7'd127;

  typedef enum logic [2:0] {
    DV_IDLE,
    DV_LOAD,
    DV_EDGE,
    DV_DIV_LO,
    DV_DIV_HI
  } dv_state_t;

endpackage

`default_nettype wire

// File: sv/jads_div.sv
`timescale 1ns / 1ps
`default_nettype none

module jads_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [jads_pkg::DATA_W-1:0]   dividend,
  input  wire logic [jads_pkg::DATA_W-1:0]   divisor,
  output logic                               busy,
  output logic                               done,
  output logic [jads_pkg::DATA_W-1:0]        quotient
);

  localparam int W = jads_pkg::DATA_W;

  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic [jads_pkg::DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]                   rem_r, rem_nxt;
  logic [W-1:0]                   quo_r, quo_nxt;
  logic [W-1:0]                   dv_r;
  logic                           zero_r;
  logic [W:0]                     trial;
  logic                           ge;

  assign trial = {rem_r, quo_r[W-1]};
  assign ge    = trial >= {1'b0, dv_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
    end else if (busy_r) begin
      rem_nxt = ge ? W'(trial - {1'b0, dv_r}) : trial[W-1:0];
      quo_nxt = {quo_r[W-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == jads_pkg::DIV_CNT_W'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      dv_r   <= divisor;
      zero_r <= divisor == '0;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = zero_r ? '0 : quo_r;

endmodule

`default_nettype wire

// File: sv/jads_axis.sv
`timescale 1ns / 1ps
`default_nettype none

module jads_axis #(
  parameter int SCALE_SHIFT = 8
) (
  input  wire logic [jads_pkg::DATA_W-1:0]         v,
  input  wire logic [jads_pkg::DATA_W-1:0]         mn,
  input  wire logic [jads_pkg::DATA_W-1:0]         mx,
  input  wire logic [jads_pkg::DATA_W-1:0]         lo,
  input  wire logic [jads_pkg::DATA_W-1:0]         hi,
  input  wire logic [jads_pkg::DATA_W-1:0]         glo,
  input  wire logic [jads_pkg::DATA_W-1:0]         ghi,
  output logic signed [jads_pkg::DELTA_W-1:0]      delta
);

  localparam int W = jads_pkg::DATA_W;

  logic           below, above;
  logic [W-1:0]   c_lo, c_hi, d_lo, d_hi, gap, gain;
  logic [2*W-1:0] prod, prod_sh;
  logic [6:0]     mag;
  logic [7:0]     mag8;

  assign below = v < lo;
  assign above = v > hi;
  assign c_lo  = (v < mn) ? mn : v;
  assign c_hi  = (v > mx) ? mx : v;
  assign d_lo  = lo - c_lo;
  assign d_hi  = c_hi - hi;
  assign gap   = below ? d_lo : d_hi;
  assign gain  = below ? glo : ghi;

  assign prod    = {{W{1'b0}}, gap} * {{W{1'b0}}, gain};
  assign prod_sh = prod >> SCALE_SHIFT;
  assign mag     = (prod_sh > (2*W)'(jads_pkg::SAT_MAG)) ? jads_pkg::SAT_MAG : prod_sh[6:0];
  assign mag8    = {1'b0, mag};

  always_comb begin
    priority if (below) begin
      delta = $signed(8'(8'd0 - mag8));
    end else if (above) begin
      delta = $signed(mag8);
    end else begin
      delta = '0;
    end
  end

endmodule

`default_nettype wire

// File: sv/joystick_axis_deadzone_scaler_top.sv
// Dead-band scaler for up to two analogue joysticks. Each input item selects
// a stick (in_tuser) and carries raw X and Y counts; each yields one result item
// with signed X and Y deltas in -127..127 and a fault flag (out_tuser) that is
// set when any side of the selected stick's dead band has zero width. Items
// are taken one per clock unless a result waits or a derivation runs, and
// pass an input register, then a result register; a result that waits holds
// off the input until it is taken. Band edges and per-side gains are held in
// registers and worked out from the limits by a sequencer around a 16-step
// shift-subtract divider, per stick after a limit write to it and for both
// sticks after reset, in_tready low; configuration writes are taken as ever.
`timescale 1ns / 1ps
`default_nettype none

module joystick_axis_deadzone_scaler_top #(
  parameter int SCALE_MAX   = 32768,
  parameter int SCALE_SHIFT = 8,
  parameter int NUM_STICKS  = 2
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  input  wire logic [31:0]                      in_tdata,   // raw_x, raw_y
  input  wire logic [0:0]                       in_tuser,   // stick_select
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic [15:0]                           out_tdata,  // delta_x, delta_y
  output logic [0:0]                            out_tuser,  // scale_fault
  input  wire logic                             cfg_we,
  input  wire logic [jads_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [jads_pkg::DATA_W-1:0]      cfg_wdata
);

  localparam int W = jads_pkg::DATA_W;

  // limits and derived band state
  logic [W-1:0] cfg_r [NUM_STICKS][4];
  logic [W-1:0] lo_r  [NUM_STICKS][2];
  logic [W-1:0] hi_r  [NUM_STICKS][2];
  logic [W-1:0] glo_r [NUM_STICKS][2];
  logic [W-1:0] ghi_r [NUM_STICKS][2];
  logic         flt_r [NUM_STICKS][2];

  logic [NUM_STICKS-1:0] dirty_r, dirty_nxt;
  jads_pkg::dv_state_t   dv_state_r, dv_state_nxt;
  logic                  ds_r, ds_nxt;
  logic                  da_r, da_nxt;
  logic [W-1:0]          r_r, third_r, wh_r;
  logic                  clr_dirty, load_en, edge_en, glo_we, ghi_we;
  logic                  div_start, div_busy, div_done;
  logic [W-1:0]          div_divisor, div_q;

  logic                  cfg_stick;
  logic                  cfg_ok;
  logic [W-1:0]          seq_mn, seq_mx, half, wl, wh;
  logic [31:0]           prod3;

  assign cfg_stick = cfg_index[2];
  assign cfg_ok    = cfg_we && (int'(cfg_stick) < NUM_STICKS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_STICKS; i++) begin
        cfg_r[i][jads_pkg::REG_X_MIN] <= '0;
        cfg_r[i][jads_pkg::REG_X_MAX] <= '1;
        cfg_r[i][jads_pkg::REG_Y_MIN] <= '0;
        cfg_r[i][jads_pkg::REG_Y_MAX] <= '1;
      end
    end else if (cfg_ok) begin
      cfg_r[cfg_stick][cfg_index[1:0]] <= cfg_wdata;
    end
  end

  // derivation sequencer
  assign seq_mn = (da_r == jads_pkg::AXIS_Y) ? cfg_r[ds_r][jads_pkg::REG_Y_MIN]
                                            : cfg_r[ds_r][jads_pkg::REG_X_MIN];
  assign seq_mx = (da_r == jads_pkg::AXIS_Y) ? cfg_r[ds_r][jads_pkg::REG_Y_MAX]
                                            : cfg_r[ds_r][jads_pkg::REG_X_MAX];
  assign prod3  = {16'b0, W'(seq_mx - seq_mn)} * jads_pkg::RECIP3;
  assign half   = r_r >> 1;
  assign wl     = half - third_r;
  assign wh     = r_r - half - third_r;

  always_comb begin
    dv_state_nxt = dv_state_r;
    ds_nxt       = ds_r;
    da_nxt       = da_r;
    clr_dirty    = 1'b0;
    load_en      = 1'b0;
    edge_en      = 1'b0;
    glo_we       = 1'b0;
    ghi_we       = 1'b0;
    div_start    = 1'b0;
    div_divisor  = wl;
    unique case (dv_state_r)
      jads_pkg::DV_IDLE: begin
        if (|dirty_r) begin
          ds_nxt       = !dirty_r[0];
          da_nxt       = jads_pkg::AXIS_X;
          clr_dirty    = 1'b1;
          dv_state_nxt = jads_pkg::DV_LOAD;
        end
      end
      jads_pkg::DV_LOAD: begin
        load_en      = 1'b1;
        dv_state_nxt = jads_pkg::DV_EDGE;
      end
      jads_pkg::DV_EDGE: begin
        edge_en      = 1'b1;
        div_start    = 1'b1;
        div_divisor  = wl;
        dv_state_nxt = jads_pkg::DV_DIV_LO;
      end
      jads_pkg::DV_DIV_LO: begin
        if (div_done) begin
          glo_we       = 1'b1;
          div_start    = 1'b1;
          div_divisor  = wh_r;
          dv_state_nxt = jads_pkg::DV_DIV_HI;
        end
      end
      jads_pkg::DV_DIV_HI: begin
        if (div_done) begin
          ghi_we = 1'b1;
          if (da_r == jads_pkg::AXIS_X) begin
            da_nxt       = jads_pkg::AXIS_Y;
            dv_state_nxt = jads_pkg::DV_LOAD;
          end else begin
            dv_state_nxt = jads_pkg::DV_IDLE;
          end
        end
      end
      default: dv_state_nxt = jads_pkg::DV_IDLE;
    endcase
  end

  always_comb begin
    dirty_nxt = dirty_r;
    if (clr_dirty) begin
      dirty_nxt[ds_nxt] = 1'b0;
    end
    if (cfg_ok) begin
      dirty_nxt[cfg_stick] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_state_r <= jads_pkg::DV_IDLE;
      dirty_r    <= '1;
      ds_r       <= 1'b0;
      da_r       <= jads_pkg::AXIS_X;
    end else begin
      dv_state_r <= dv_state_nxt;
      dirty_r    <= dirty_nxt;
      ds_r       <= ds_nxt;
      da_r       <= da_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_en) begin
      r_r     <= seq_mx - seq_mn;
      third_r <= W'(prod3 >> jads_pkg::RECIP3_SHIFT);
    end
    if (edge_en) begin
      lo_r[ds_r][da_r]  <= wl + seq_mn;
      hi_r[ds_r][da_r]  <= half + third_r + seq_mn;
      flt_r[ds_r][da_r] <= (wl == '0) || (wh == '0);
      wh_r              <= wh;
    end
    if (glo_we) begin
      glo_r[ds_r][da_r] <= div_q;
    end
    if (ghi_we) begin
      ghi_r[ds_r][da_r] <= div_q;
    end
  end

  jads_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (W'(SCALE_MAX)),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  // item path
  logic         adv, in_fire, derive_idle;
  logic         s1_vld_r;
  logic         s1_stick_r;
  logic [W-1:0] s1_x_r, s1_y_r;
  logic         out_vld_r;
  logic [15:0]  out_data_r;
  logic         out_flt_r;
  logic         stick_ok, st;
  logic signed [jads_pkg::DELTA_W-1:0] dx, dy;

  assign derive_idle = (dv_state_r == jads_pkg::DV_IDLE) && !(|dirty_r);
  assign adv         = !out_vld_r || out_tready;
  assign in_tready   = adv && derive_idle;
  assign in_fire     = in_tvalid && in_tready;

  assign stick_ok = int'(s1_stick_r) < NUM_STICKS;
  assign st       = stick_ok ? s1_stick_r : 1'b0;

  jads_axis #(.SCALE_SHIFT(SCALE_SHIFT)) u_axis_x (
    .v     (s1_x_r),
    .mn    (cfg_r[st][jads_pkg::REG_X_MIN]),
    .mx    (cfg_r[st][jads_pkg::REG_X_MAX]),
    .lo    (lo_r[st][jads_pkg::AXIS_X]),
    .hi    (hi_r[st][jads_pkg::AXIS_X]),
    .glo   (glo_r[st][jads_pkg::AXIS_X]),
    .ghi   (ghi_r[st][jads_pkg::AXIS_X]),
    .delta (dx)
  );

  jads_axis #(.SCALE_SHIFT(SCALE_SHIFT)) u_axis_y (
    .v     (s1_y_r),
    .mn    (cfg_r[st][jads_pkg::REG_Y_MIN]),
    .mx    (cfg_r[st][jads_pkg::REG_Y_MAX]),
    .lo    (lo_r[st][jads_pkg::AXIS_Y]),
    .hi    (hi_r[st][jads_pkg::AXIS_Y]),
    .glo   (glo_r[st][jads_pkg::AXIS_Y]),
    .ghi   (ghi_r[st][jads_pkg::AXIS_Y]),
    .delta (dy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r  <= in_fire;
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_stick_r <= in_tuser[0];
      s1_x_r     <= in_tdata[15:0];
      s1_y_r     <= in_tdata[31:16];
    end
    if (adv && s1_vld_r) begin
      out_data_r <= stick_ok ? {dy, dx} : '0;
      out_flt_r  <= stick_ok && (flt_r[st][jads_pkg::AXIS_X] || flt_r[st][jads_pkg::AXIS_Y]);
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_flt_r;

  a_no_take_while_deriving: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_state_r != jads_pkg::DV_IDLE) |-> !in_tready)
    else $error("item taken while band state is being derived");

  a_in_to_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> s1_vld_r)
    else $error("accepted item lost before the input register");

  a_stage_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && adv) |=> out_vld_r)
    else $error("item dropped between input and result register");

  a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_state_r == jads_pkg::DV_DIV_LO || dv_state_r == jads_pkg::DV_DIV_HI)
      |-> (div_busy || div_done))
    else $error("sequencer waits on an idle divider");

endmodule

`default_nettype wire

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int SCALE_MAX   = 32768;
  localparam int SCALE_SHIFT = 8;
  localparam int STALL_LEN   = 400;

  typedef struct {
    logic        stick;
    logic [15:0] raw_x;
    logic [15:0] raw_y;
  } sample_t;

  typedef struct {
    logic [7:0] delta_x;
    logic [7:0] delta_y;
    logic       fault;
  } motion_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [31:0]                    in_tdata   = '0;   // raw_x, raw_y
  logic [0:0]                     in_tuser   = '0;   // stick_select
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [15:0]                    out_tdata;         // delta_x, delta_y
  logic [0:0]                     out_tuser;         // scale_fault
  logic                           cfg_we     = 1'b0;
  logic [jads_pkg::CFG_IDX_W-1:0] cfg_index  = '0;
  logic [jads_pkg::DATA_W-1:0]    cfg_wdata  = '0;

  sample_t     pending_samples[$];
  motion_t     expected_motion[$];
  sample_t     next_sample;
  sample_t     seen_sample;
  motion_t     got_motion;
  motion_t     want_motion;

  logic [15:0] limits  [2][4];
  logic [15:0] band_lo [2][2];
  logic [15:0] band_hi [2][2];
  logic [15:0] gain_lo [2][2];
  logic [15:0] gain_hi [2][2];

  int n_queued   = 0;
  int n_accepted = 0;
  int errors     = 0;
  int hold_left  = 0;
  bit item_taken = 1'b0;
  bit no_idle    = 1'b0;
  bit stall_req  = 1'b0;

  joystick_axis_deadzone_scaler_top #(
    .SCALE_MAX  (SCALE_MAX),
    .SCALE_SHIFT(SCALE_SHIFT),
    .NUM_STICKS (2)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void rederive_bands(int s);
    logic [15:0] mn, mx, r, half, third, wlo, whi;
    for (int a = 0; a < 2; a++) begin
      mn = limits[s][a ? jads_pkg::REG_Y_MIN : jads_pkg::REG_X_MIN];
      mx = limits[s][a ? jads_pkg::REG_Y_MAX : jads_pkg::REG_X_MAX];
      r = mx - mn;
      half = r >> 1;
      third = r / 3;
      band_lo[s][a] = mn + half - third;
      band_hi[s][a] = mn + half + third;
      wlo = half - third;
      whi = r - half - third;
      gain_lo[s][a] = (wlo == 16'd0) ? 16'd0 : 16'(SCALE_MAX / wlo);
      gain_hi[s][a] = (whi == 16'd0) ? 16'd0 : 16'(SCALE_MAX / whi);
    end
  endfunction

  function automatic bit side_closed(logic [15:0] mn, logic [15:0] mx,
                                     logic [15:0] lo, logic [15:0] hi);
    logic [15:0] wl, wh;
    wl = lo - mn;
    wh = mx - hi;
    return (wl == 16'd0) || (wh == 16'd0);
  endfunction

  function automatic logic [7:0] axis_move(logic [15:0] v, logic [15:0] mn,
                                           logic [15:0] mx, logic [15:0] lo,
                                           logic [15:0] hi, logic [15:0] glo,
                                           logic [15:0] ghi);
    logic [15:0] c, gap, g;
    logic [31:0] prod;
    logic [7:0]  mag;
    if (v < lo) begin
      c = (v < mn) ? mn : v;
      gap = lo - c;
      g = glo;
    end else if (v > hi) begin
      c = (v > mx) ? mx : v;
      gap = c - hi;
      g = ghi;
    end else begin
      return 8'd0;
    end
    prod = (32'(gap) * 32'(g)) >> SCALE_SHIFT;
    mag = (prod > 32'd127) ? 8'd127 : prod[7:0];
    return (v < lo) ? 8'd0 - mag : mag;
  endfunction

  function automatic motion_t predict_motion(sample_t smp);
    motion_t m;
    int s;
    s = smp.stick;
    m.delta_x = axis_move(smp.raw_x,
                          limits[s][jads_pkg::REG_X_MIN], limits[s][jads_pkg::REG_X_MAX],
                          band_lo[s][jads_pkg::AXIS_X], band_hi[s][jads_pkg::AXIS_X],
                          gain_lo[s][jads_pkg::AXIS_X], gain_hi[s][jads_pkg::AXIS_X]);
    m.delta_y = axis_move(smp.raw_y,
                          limits[s][jads_pkg::REG_Y_MIN], limits[s][jads_pkg::REG_Y_MAX],
                          band_lo[s][jads_pkg::AXIS_Y], band_hi[s][jads_pkg::AXIS_Y],
                          gain_lo[s][jads_pkg::AXIS_Y], gain_hi[s][jads_pkg::AXIS_Y]);
    m.fault = side_closed(limits[s][jads_pkg::REG_X_MIN], limits[s][jads_pkg::REG_X_MAX],
                          band_lo[s][jads_pkg::AXIS_X], band_hi[s][jads_pkg::AXIS_X]) ||
              side_closed(limits[s][jads_pkg::REG_Y_MIN], limits[s][jads_pkg::REG_Y_MAX],
                          band_lo[s][jads_pkg::AXIS_Y], band_hi[s][jads_pkg::AXIS_Y]);
    return m;
  endfunction

  function automatic logic [15:0] pick_raw(logic [15:0] mn, logic [15:0] mx);
    logic [15:0] span;
    int roll;
    span = mx - mn;
    roll = $urandom_range(99);
    if (roll < 25) return 16'($urandom);
    if (roll < 32) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
    return mn + 16'($urandom_range(int'(span) + int'(span) / 2 + 16))
              - 16'(int'(span) / 4 + 8);
  endfunction

  task automatic push_sample(logic s, logic [15:0] x, logic [15:0] y);
    sample_t smp;
    smp.stick = s;
    smp.raw_x = x;
    smp.raw_y = y;
    pending_samples.push_back(smp);
    n_queued++;
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || expected_motion.size() != 0) @(posedge clk);
  endtask

  task automatic write_limit(logic s, logic [1:0] slot, logic [15:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= {s, slot};
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    limits[s][slot] = value;
    rederive_bands(s);
    // let the band sequencer start, then hold until it is done
    repeat (2) @(negedge clk);
    while (!in_tready) @(negedge clk);
  endtask

  task automatic pick_limits(logic s);
    logic [15:0] mn, mx;
    int mode;
    for (int a = 0; a < 2; a++) begin
      mode = $urandom_range(4);
      mn = 16'($urandom);
      case (mode)
        0: mx = 16'($urandom);
        1: mx = mn + 16'($urandom_range(600));
        2: mx = mn + 16'($urandom_range(3));
        3: mx = mn - 16'($urandom_range(2000, 1));
        default: begin
          mn = $urandom_range(1) ? 16'hFFFF : 16'h0000;
          mx = $urandom_range(1) ? 16'hFFFF : 16'h0000;
        end
      endcase
      write_limit(s, a ? jads_pkg::REG_Y_MIN : jads_pkg::REG_X_MIN, mn);
      write_limit(s, a ? jads_pkg::REG_Y_MAX : jads_pkg::REG_X_MAX, mx);
    end
  endtask

  // driver: offer the next pending item, hold it until taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || item_taken) begin
      item_taken = 1'b0;
      if (pending_samples.size() != 0 && (no_idle || $urandom_range(99) >= 22)) begin
        next_sample = pending_samples.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {next_sample.raw_y, next_sample.raw_x};
        in_tuser  <= next_sample.stick;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // receiver back-pressure
  always @(negedge clk) begin
    if (stall_req) begin
      hold_left = STALL_LEN;
      stall_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= no_idle || ($urandom_range(99) >= 22);
    end
  end

  // monitor: predict on input handshake, check on output handshake
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      seen_sample.stick = in_tuser[0];
      seen_sample.raw_x = in_tdata[15:0];
      seen_sample.raw_y = in_tdata[31:16];
      expected_motion.push_back(predict_motion(seen_sample));
      n_accepted++;
      item_taken = 1'b1;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got_motion.delta_x = out_tdata[7:0];
      got_motion.delta_y = out_tdata[15:8];
      got_motion.fault   = out_tuser[0];
      if (expected_motion.size() == 0) begin
        $error("result item with nothing expected: delta_x %0d delta_y %0d fault %0b",
               $signed(got_motion.delta_x), $signed(got_motion.delta_y), got_motion.fault);
        errors++;
      end else begin
        want_motion = expected_motion.pop_front();
        if (got_motion.delta_x !== want_motion.delta_x) begin
          $error("delta_x: expected %0d, actual %0d",
                 $signed(want_motion.delta_x), $signed(got_motion.delta_x));
          errors++;
        end
        if (got_motion.delta_y !== want_motion.delta_y) begin
          $error("delta_y: expected %0d, actual %0d",
                 $signed(want_motion.delta_y), $signed(got_motion.delta_y));
          errors++;
        end
        if (got_motion.fault !== want_motion.fault) begin
          $error("scale_fault: expected %0b, actual %0b",
                 want_motion.fault, got_motion.fault);
          errors++;
        end
      end
    end
  end

  initial begin
    logic s;
    for (int k = 0; k < 2; k++) begin
      limits[k][jads_pkg::REG_X_MIN] = 16'h0000;
      limits[k][jads_pkg::REG_X_MAX] = 16'hFFFF;
      limits[k][jads_pkg::REG_Y_MIN] = 16'h0000;
      limits[k][jads_pkg::REG_Y_MAX] = 16'hFFFF;
      rederive_bands(k);
    end
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset limits: full range, band edges and both extremes
    push_sample(1'b0, 16'h0000, 16'hFFFF);
    push_sample(1'b0, 16'hFFFF, 16'h0000);
    push_sample(1'b0, 16'd10921, 16'd10922);
    push_sample(1'b0, 16'd54612, 16'd54613);
    push_sample(1'b0, 16'd32768, 16'd32768);
    push_sample(1'b0, 16'd10922, 16'd54612);
    push_sample(1'b1, 16'h0000, 16'h0000);
    push_sample(1'b1, 16'hFFFF, 16'hFFFF);
    wait_drained();

    // narrow span, minimum above maximum, zero-width and one-count spans
    write_limit(1'b0, jads_pkg::REG_X_MIN, 16'd1000);
    write_limit(1'b0, jads_pkg::REG_X_MAX, 16'd3000);
    write_limit(1'b0, jads_pkg::REG_Y_MIN, 16'd3000);
    write_limit(1'b0, jads_pkg::REG_Y_MAX, 16'd1000);
    write_limit(1'b1, jads_pkg::REG_X_MIN, 16'd500);
    write_limit(1'b1, jads_pkg::REG_X_MAX, 16'd500);
    write_limit(1'b1, jads_pkg::REG_Y_MIN, 16'd0);
    write_limit(1'b1, jads_pkg::REG_Y_MAX, 16'd1);
    push_sample(1'b0, 16'd0, 16'd0);
    push_sample(1'b0, 16'd1000, 16'd3000);
    push_sample(1'b0, 16'd2000, 16'd2000);
    push_sample(1'b0, 16'hFFFF, 16'hFFFF);
    push_sample(1'b0, 16'd3000, 16'd1000);
    push_sample(1'b1, 16'd500, 16'd0);
    push_sample(1'b1, 16'd499, 16'd1);
    push_sample(1'b1, 16'd501, 16'hFFFF);
    wait_drained();

    // register extremes
    write_limit(1'b0, jads_pkg::REG_X_MIN, 16'hFFFF);
    write_limit(1'b0, jads_pkg::REG_X_MAX, 16'h0000);
    write_limit(1'b0, jads_pkg::REG_Y_MIN, 16'h0000);
    write_limit(1'b0, jads_pkg::REG_Y_MAX, 16'hFFFF);
    write_limit(1'b1, jads_pkg::REG_X_MIN, 16'h0000);
    write_limit(1'b1, jads_pkg::REG_X_MAX, 16'd2);
    write_limit(1'b1, jads_pkg::REG_Y_MIN, 16'hFFFF);
    write_limit(1'b1, jads_pkg::REG_Y_MAX, 16'hFFFF);
    push_sample(1'b0, 16'h0000, 16'h0000);
    push_sample(1'b0, 16'hFFFF, 16'hFFFF);
    push_sample(1'b0, 16'h8000, 16'h7FFF);
    push_sample(1'b1, 16'd0, 16'hFFFF);
    push_sample(1'b1, 16'd1, 16'h0000);
    push_sample(1'b1, 16'd2, 16'h1234);
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      pick_limits(1'b0);
      pick_limits(1'b1);
      no_idle = (p == 4);
      if (p == 2) begin
        @(posedge clk);
        stall_req = 1'b1;
      end
      for (int i = 0; i < 100; i++) begin
        s = $urandom_range(1);
        push_sample(s,
                    pick_raw(limits[s][jads_pkg::REG_X_MIN], limits[s][jads_pkg::REG_X_MAX]),
                    pick_raw(limits[s][jads_pkg::REG_Y_MIN], limits[s][jads_pkg::REG_Y_MAX]));
      end
      wait_drained();
    end
    no_idle = 1'b0;

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_motion.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #4_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
